[sv/utf8v_pkg.sv]
package utf8v_pkg;

    // Error codes, in the order of the result's error_code field.
    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_LEAD     = 3'd2,
        ERR_TRUNC    = 3'd3,
        ERR_CONT     = 3'd4,
        ERR_OVERLONG = 3'd5,
        ERR_RANGE    = 3'd6,
        ERR_TOOLONG  = 3'd7
    } err_t;

    // Extra check applied to the second byte of a multi-byte sequence.
    typedef enum logic [2:0] {
        RULE_NONE   = 3'd0,
        RULE_MIN_A0 = 3'd1,
        RULE_MAX_9F = 3'd2,
        RULE_MIN_90 = 3'd3,
        RULE_MAX_8F = 3'd4
    } rule_t;

    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned MAX_W    = 6;
    localparam logic [MAX_W-1:0] MAX_CHARS_RESET = 6'd20;

    localparam logic [7:0] ASCII_HI = 8'h7F;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] SEC_A0   = 8'hA0;
    localparam logic [7:0] SEC_9F   = 8'h9F;
    localparam logic [7:0] SEC_90   = 8'h90;
    localparam logic [7:0] SEC_8F   = 8'h8F;

    // Per-string decoder state.
    typedef struct packed {
        logic [1:0]        cont_left;
        rule_t             rule;
        logic              at_second;
        logic [CHAR_W-1:0] chars;
        err_t              first_err;
        logic              saw_any;
    } dec_state_t;

    // One verdict.
    typedef struct packed {
        logic              is_valid;
        logic [CHAR_W-1:0] char_count;
        err_t              error_code;
    } verdict_t;

endpackage

[sv/utf8v_step.sv]
module utf8v_step (
    input  utf8v_pkg::dec_state_t       state,
    input  logic [7:0]                  data_byte,
    input  logic                        has_byte,
    input  logic                        last,
    input  logic [utf8v_pkg::MAX_W-1:0] max_chars,
    output utf8v_pkg::dec_state_t       state_next,
    output utf8v_pkg::verdict_t         verdict
);
    import utf8v_pkg::*;

    dec_state_t        upd;
    logic              char_done;
    logic              bad_ovl;
    logic              bad_rng;
    logic [CHAR_W-1:0] max_ext;
    err_t              code;

    assign max_ext = {1'b0, max_chars};

    always_comb
    begin
        upd       = state;
        char_done = 1'b0;
        bad_ovl   = 1'b0;
        bad_rng   = 1'b0;
        if (has_byte)
        begin
            upd.saw_any = 1'b1;
            if (state.first_err == ERR_OK)
            begin
                if (state.cont_left == 2'd0)
                begin
                    // Lead byte.
                    if (data_byte <= ASCII_HI)
                    begin
                        char_done = 1'b1;
                    end
                    else if (data_byte inside {[LEAD2_LO:LEAD2_HI]})
                    begin
                        upd.cont_left = 2'd1;
                        upd.rule      = RULE_NONE;
                        upd.at_second = 1'b1;
                    end
                    else if (data_byte inside {[LEAD3_LO:LEAD3_HI]})
                    begin
                        upd.cont_left = 2'd2;
                        upd.rule      = (data_byte == LEAD3_LO) ? RULE_MIN_A0 :
                                        (data_byte == LEAD_ED)  ? RULE_MAX_9F : RULE_NONE;
                        upd.at_second = 1'b1;
                    end
                    else if (data_byte inside {[LEAD4_LO:LEAD4_HI]})
                    begin
                        upd.cont_left = 2'd3;
                        upd.rule      = (data_byte == LEAD4_LO) ? RULE_MIN_90 :
                                        (data_byte == LEAD4_HI) ? RULE_MAX_8F : RULE_NONE;
                        upd.at_second = 1'b1;
                    end
                    else
                    begin
                        upd.first_err = ERR_LEAD;
                    end
                end
                else
                begin
                    // Continuation byte.
                    if (!(data_byte inside {[CONT_LO:CONT_HI]}))
                    begin
                        upd.first_err = ERR_CONT;
                    end
                    else
                    begin
                        if (state.at_second)
                        begin
                            upd.at_second = 1'b0;
                            bad_ovl = (state.rule == RULE_MIN_A0 && data_byte < SEC_A0) ||
                                      (state.rule == RULE_MAX_9F && data_byte > SEC_9F) ||
                                      (state.rule == RULE_MIN_90 && data_byte < SEC_90);
                            bad_rng = (state.rule == RULE_MAX_8F && data_byte > SEC_8F);
                        end
                        if (bad_ovl)
                        begin
                            upd.first_err = ERR_OVERLONG;
                        end
                        else if (bad_rng)
                        begin
                            upd.first_err = ERR_RANGE;
                        end
                        else
                        begin
                            upd.cont_left = state.cont_left - 2'd1;
                            char_done     = (state.cont_left == 2'd1);
                        end
                    end
                end
            end
        end

        // The count saturates one above the limit; passing the limit is a fault.
        if (char_done)
        begin
            if (state.chars <= max_ext)
            begin
                upd.chars = state.chars + 7'd1;
            end
            if (upd.chars > max_ext)
            begin
                upd.first_err = ERR_TOOLONG;
            end
        end

        code = upd.first_err;
        if (code == ERR_OK)
        begin
            if (!upd.saw_any)
            begin
                code = ERR_EMPTY;
            end
            else if (upd.cont_left != 2'd0)
            begin
                code = ERR_TRUNC;
            end
        end
        verdict.is_valid   = (code == ERR_OK);
        verdict.char_count = upd.chars;
        verdict.error_code = code;

        state_next = last ? dec_state_t'('0) : upd;
    end

endmodule

[sv/utf8_validator_char_limit.sv]
// UTF-8 validator with a character limit. Bytes of a string arrive one per input
// item; s_axis_tuser marks whether the item really carries a byte and s_axis_tlast
// closes the string. The block checks strict UTF-8 (no overlong forms, no
// surrogates, nothing above U+10FFFF), rejects empty and truncated strings, and
// flags a string holding more than max_chars characters. Exactly one verdict item
// leaves on m_axis for each input item marked last, and the per-string state is
// then cleared. The error code holds the first fault met in byte order, and the
// character count stops at the value it had when that fault was found, saturating
// at max_chars + 1. Throughput is one item per clock: an input register feeds
// combinational decode logic that updates the string state and loads the verdict
// register. When an item that closes a string leaves the input register, its
// verdict is loaded into the verdict register, which drives m_axis_tvalid. Only a
// verdict item waiting on a stalled m_axis can hold up the input. max_chars is
// written through cfg_we / cfg_wdata and resets to 20; it should only be changed
// between strings.
module utf8_validator_char_limit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,      // max_chars

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last item of the string

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] char_count, [9:7] error_code, rest zero
    output logic        m_axis_tuser    // [0] is_valid
);
    import utf8v_pkg::*;

    // Limit register.
    logic [MAX_W-1:0] max_chars_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // String state and verdict register.
    dec_state_t state_reg;
    dec_state_t state_next;
    verdict_t   verdict_next;
    verdict_t   out_reg;
    logic       out_valid_reg;

    logic consume;
    logic in_take;

    // An item in the input register is processed unless it would produce a verdict
    // while the verdict register is still full and not being emptied.
    assign consume = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    utf8v_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .has_byte   (in_has_reg),
        .last       (in_last_reg),
        .max_chars  (max_chars_reg),
        .state_next (state_next),
        .verdict    (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= MAX_CHARS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_chars_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
            if (consume && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
        if (consume && in_last_reg)
        begin
            out_reg <= verdict_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.is_valid;
    assign m_axis_tdata  = {6'd0, out_reg.error_code, out_reg.char_count};

    // A verdict is valid exactly when its error code is clear.
    a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (out_reg.error_code == ERR_OK)))
        else $error("is_valid disagrees with error_code");

    // The second-byte marker only lives inside an open sequence.
    a_second_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.cont_left == 2'd0) |-> !state_reg.at_second)
        else $error("at_second set with no sequence open");

    // Once a fault is recorded the count freezes until the string ends.
    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.first_err != ERR_OK && !(consume && in_last_reg))
            |=> $stable(state_reg.chars))
        else $error("character count moved after a fault");

    // A verdict is loaded only on the cycle after the last item is processed.
    a_verdict_load: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> m_axis_tvalid)
        else $error("verdict not presented after last item");

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8v_pkg::*;

    // One input item as the sender presents it: the byte, whether the item
    // really carries a byte, and whether it closes the string.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } byte_item_t;

    // The watchdog limit is far beyond the slowest correct run, even with the
    // heaviest idling.
    localparam int unsigned RUN_LIMIT     = 200000;
    // Cycles for an accepted item to pass the input register and the decode
    // stage, with margin, before the block counts as idle.
    localparam int unsigned SETTLE_CYCLES = 6;
    // Length of the long receiver hold-off.
    localparam int unsigned LONG_STALL    = 300;
    // Random items per idling phase.
    localparam int unsigned PHASE_ITEMS   = 150;
    localparam int unsigned REPORT_MAX    = 10;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    utf8_validator_char_limit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Items waiting to be offered, and verdicts predicted but not yet seen.
    byte_item_t  pending_bytes [$];
    verdict_t    verdicts_due [$];
    byte_item_t  offered_byte;
    bit          offering;

    // Scratch buffer where one random string is assembled before queuing.
    logic [7:0]  string_bytes [$];
    int unsigned random_items;

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 67;
    logic        stall_request = 1'b0;
    int unsigned stall_left;
    int unsigned fault_count = 0;
    int unsigned run_cycles;

    // Shadow of the decoder: configuration plus per-string state.
    logic [5:0]  limit_m;
    logic [1:0]  cont_left_m;
    rule_t       rule_m;
    logic        second_m;
    logic [6:0]  count_m;
    err_t        err_m;
    logic        any_m;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The watchdog counts clock cycles. Reaching the limit means the block
    // stopped accepting items or stopped producing verdicts.
    initial
    begin : watchdog
        run_cycles = 0;
        while (run_cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            run_cycles++;
        end
        $display("timeout after %0d cycles, %0d verdicts outstanding", run_cycles,
                 verdicts_due.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    function automatic void clear_string_model();
        cont_left_m = '0;
        rule_m      = RULE_NONE;
        second_m    = 1'b0;
        count_m     = '0;
        err_m       = ERR_OK;
        any_m       = 1'b0;
    endfunction

    // A completed character. The count saturates one above the limit, and
    // reaching that point is the too-long fault. With a limit of zero the
    // very first character already triggers it.
    function automatic void count_char();
        if (count_m <= {1'b0, limit_m})
            count_m = count_m + 7'd1;
        if (count_m > {1'b0, limit_m})
            err_m = ERR_TOOLONG;
    endfunction

    // Advances the shadow decoder by one accepted item and, when the item
    // closes the string, queues the verdict the block must produce for it.
    function automatic void decode_utf8_item(input byte_item_t it);
        verdict_t   v;
        err_t       code;
        logic [7:0] b;
        bit         bad_second;
        b = it.data;
        bad_second = 1'b0;
        if (it.has)
        begin
            any_m = 1'b1;
            // Once a fault is recorded, the rest of the string is ignored.
            if (err_m == ERR_OK)
            begin
                if (cont_left_m == 2'd0)
                begin
                    if (b <= ASCII_HI)
                    begin
                        count_char();
                    end
                    else if (b >= LEAD2_LO && b <= LEAD2_HI)
                    begin
                        cont_left_m = 2'd1;
                        rule_m      = RULE_NONE;
                        second_m    = 1'b1;
                    end
                    else if (b >= LEAD3_LO && b <= LEAD3_HI)
                    begin
                        cont_left_m = 2'd2;
                        rule_m      = (b == LEAD3_LO) ? RULE_MIN_A0 :
                                      (b == LEAD_ED)  ? RULE_MAX_9F : RULE_NONE;
                        second_m    = 1'b1;
                    end
                    else if (b >= LEAD4_LO && b <= LEAD4_HI)
                    begin
                        cont_left_m = 2'd3;
                        rule_m      = (b == LEAD4_LO) ? RULE_MIN_90 :
                                      (b == LEAD4_HI) ? RULE_MAX_8F : RULE_NONE;
                        second_m    = 1'b1;
                    end
                    else
                    begin
                        err_m = ERR_LEAD;
                    end
                end
                else if (b < CONT_LO || b > CONT_HI)
                begin
                    err_m = ERR_CONT;
                end
                else
                begin
                    // The second byte carries the overlong, surrogate and
                    // range checks chosen by the lead byte.
                    if (second_m)
                    begin
                        second_m = 1'b0;
                        if ((rule_m == RULE_MIN_A0 && b < SEC_A0) ||
                            (rule_m == RULE_MAX_9F && b > SEC_9F) ||
                            (rule_m == RULE_MIN_90 && b < SEC_90))
                        begin
                            err_m = ERR_OVERLONG;
                            bad_second = 1'b1;
                        end
                        else if (rule_m == RULE_MAX_8F && b > SEC_8F)
                        begin
                            err_m = ERR_RANGE;
                            bad_second = 1'b1;
                        end
                    end
                    if (!bad_second)
                    begin
                        cont_left_m = cont_left_m - 2'd1;
                        if (cont_left_m == 2'd0)
                            count_char();
                    end
                end
            end
        end
        if (it.last)
        begin
            code = err_m;
            if (code == ERR_OK)
            begin
                if (!any_m)
                    code = ERR_EMPTY;
                else if (cont_left_m != 2'd0)
                    code = ERR_TRUNC;
            end
            v.is_valid   = (code == ERR_OK);
            v.char_count = count_m;
            v.error_code = code;
            verdicts_due.push_back(v);
            clear_string_model();
        end
    endfunction

    // Sender. An item counts as accepted at the edge where tvalid and tready
    // are both high; that is where the prediction is made. A new item is
    // then offered unless the sender decides to idle this cycle. tvalid gets
    // exactly one assignment per edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_utf8_item(offered_byte);
                offering = 1'b0;
            end
            if (!offering && pending_bytes.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                offered_byte = pending_bytes.pop_front();
                s_axis_tdata <= offered_byte.data;
                s_axis_tuser <= offered_byte.has;
                s_axis_tlast <= offered_byte.last;
                offering = 1'b1;
            end
            s_axis_tvalid <= offering;
        end
    end

    // Long receiver hold-off, counted here so the stimulus only has to ask.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_request)
            stall_left <= LONG_STALL;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Receiver: random back-pressure, and tready held low during a hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: each accepted verdict is matched against the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t   want;
        logic [6:0] got_count;
        logic [2:0] got_code;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_count = m_axis_tdata[6:0];
            got_code  = m_axis_tdata[9:7];
            if (verdicts_due.size() == 0)
            begin
                report_fault($sformatf("unexpected verdict: valid=%0b count=%0d code=%0d",
                                       m_axis_tuser, got_count, got_code));
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_axis_tuser !== want.is_valid || got_count !== want.char_count ||
                    got_code !== want.error_code)
                begin
                    report_fault({
                        $sformatf("verdict mismatch: expected valid=%0b count=%0d code=%0d",
                                  want.is_valid, want.char_count, want.error_code),
                        $sformatf(", got valid=%0b count=%0d code=%0d",
                                  m_axis_tuser, got_count, got_code)});
                end
            end
        end
    end

    task automatic push_item(input logic [7:0] data, input logic has, input logic last);
        byte_item_t it;
        it.data = data;
        it.has  = has;
        it.last = last;
        pending_bytes.push_back(it);
    endtask

    // Waits until the sender has nothing left, every predicted verdict has
    // arrived, and the pipeline has had time to swallow items that cause no
    // verdict. Sampled on the falling edge so the check is free of races.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_chars(input logic [5:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        limit_m = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Appends one character to the scratch string. Most characters are
    // well formed, with the lead bytes that carry second-byte rules picked
    // often; a few are corrupted, cut short, or get an arbitrary second byte
    // so the overlong, surrogate and range checks fire.
    task automatic append_char();
        logic [7:0]  seq [4];
        int unsigned n;
        int unsigned r;
        int unsigned i;
        case ($urandom_range(3))
            0:
            begin
                n = 1;
                seq[0] = 8'($urandom_range(ASCII_HI, 0));
            end
            1:
            begin
                n = 2;
                seq[0] = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            end
            2:
            begin
                n = 3;
                if ($urandom_range(9) < 3)
                    seq[0] = $urandom_range(1) ? LEAD3_LO : LEAD_ED;
                else
                    seq[0] = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
            end
            default:
            begin
                n = 4;
                if ($urandom_range(9) < 4)
                    seq[0] = $urandom_range(1) ? LEAD4_LO : LEAD4_HI;
                else
                    seq[0] = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
            end
        endcase
        for (i = 1; i < n; i++)
            seq[2'(i)] = 8'($urandom_range(CONT_HI, CONT_LO));
        // Keep the second byte legal for the rule the lead byte implies.
        if (seq[0] == LEAD3_LO)
            seq[1] = 8'($urandom_range(CONT_HI, SEC_A0));
        else if (seq[0] == LEAD_ED)
            seq[1] = 8'($urandom_range(SEC_9F, CONT_LO));
        else if (seq[0] == LEAD4_LO)
            seq[1] = 8'($urandom_range(CONT_HI, SEC_90));
        else if (seq[0] == LEAD4_HI)
            seq[1] = 8'($urandom_range(SEC_8F, CONT_LO));
        r = $urandom_range(99);
        if (r < 8)
            seq[2'($urandom_range(n - 1))] = 8'($urandom_range(255));
        else if (r < 12 && n > 1)
            n = $urandom_range(n - 1, 1);
        else if (r < 18 && n > 1)
            seq[1] = 8'($urandom_range(CONT_HI, CONT_LO));
        for (i = 0; i < n; i++)
            string_bytes.push_back(seq[2'(i)]);
    endtask

    // Queues one random string. Its length mostly stays at five or below (and
    // within max_len), now and then up to max_len. The string ends either on its last
    // byte or on a separate end marker that carries no byte, and now and
    // then an empty item is slipped in that the block must ignore.
    task automatic queue_random_string(input int unsigned max_len);
        int unsigned len;
        int unsigned i;
        bit          end_on_byte;
        string_bytes.delete();
        if ($urandom_range(14) == 0)
            len = $urandom_range(max_len);
        else
            len = $urandom_range((max_len < 5) ? max_len : 5);
        if ($urandom_range(19) == 0)
        begin
            // Plain noise: arbitrary bytes with no structure.
            for (i = 0; i < len; i++)
                string_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            for (i = 0; i < len; i++)
                append_char();
        end
        end_on_byte = 1'($urandom_range(1));
        for (i = 0; i < string_bytes.size(); i++)
        begin
            if ($urandom_range(11) == 0)
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            push_item(string_bytes[i], 1'b1, end_on_byte && (i == string_bytes.size() - 1));
            random_items++;
        end
        if (!end_on_byte || string_bytes.size() == 0)
        begin
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
            random_items++;
        end
    endtask

    task automatic run_random_phase(input logic [5:0] limit, input int unsigned send_pct,
                                    input int unsigned recv_pct);
        write_max_chars(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_items = 0;
        while (random_items < PHASE_ITEMS)
            queue_random_string(int'(limit) + 2);
        wait_idle();
    endtask

    initial
    begin : stimulus
        limit_m = MAX_CHARS_RESET;
        clear_string_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings, starting at the reset limit of 20.
        // Empty string: only an end marker.
        push_item(8'h00, 1'b0, 1'b1);
        // Extremes of one- and two-byte characters, with an ignored empty item.
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(ASCII_HI, 1'b1, 1'b0);
        push_item(LEAD2_LO, 1'b1, 1'b0);
        push_item(CONT_LO, 1'b1, 1'b0);
        push_item(LEAD2_HI, 1'b1, 1'b0);
        push_item(CONT_HI, 1'b1, 1'b1);
        // Lead byte that can only start an overlong form.
        push_item(8'hC1, 1'b1, 1'b0);
        push_item(CONT_LO, 1'b1, 1'b1);
        // Overlong three-byte form.
        push_item(LEAD3_LO, 1'b1, 1'b0);
        push_item(SEC_9F, 1'b1, 1'b1);
        // Surrogate.
        push_item(LEAD_ED, 1'b1, 1'b0);
        push_item(SEC_A0, 1'b1, 1'b1);
        // Above U+10FFFF.
        push_item(LEAD4_HI, 1'b1, 1'b0);
        push_item(SEC_90, 1'b1, 1'b1);
        // Overlong four-byte form.
        push_item(LEAD4_LO, 1'b1, 1'b0);
        push_item(SEC_8F, 1'b1, 1'b1);
        // U+10FFFF itself is legal.
        push_item(LEAD4_HI, 1'b1, 1'b0);
        push_item(SEC_8F, 1'b1, 1'b0);
        push_item(CONT_HI, 1'b1, 1'b0);
        push_item(CONT_HI, 1'b1, 1'b1);
        // Truncated: the end marker arrives inside a sequence.
        push_item(8'hE1, 1'b1, 1'b0);
        push_item(CONT_LO, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        // A bad continuation wins over the truncation it also causes.
        push_item(LEAD2_LO, 1'b1, 1'b0);
        push_item(8'h41, 1'b1, 1'b1);
        // Bad lead after one good character: the count stays at one.
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        // Open a string, then lower the limit before it closes.
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b0);
        wait_idle();
        write_max_chars(6'd1);
        push_item(8'h64, 1'b1, 1'b1);
        // Two characters against a limit of one.
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h42, 1'b1, 1'b1);
        wait_idle();
        // A limit of zero rejects the first character.
        write_max_chars(6'd0);
        push_item(8'h41, 1'b1, 1'b1);
        wait_idle();

        // Hold the receiver off while the sender floods the block, so the
        // verdict register fills and the input stalls.
        write_max_chars(6'd63);
        send_idle_pct = 0;
        stall_request <= 1'b1;
        @(posedge clk);
        stall_request <= 1'b0;
        repeat (40) queue_random_string(3);
        wait_idle();

        run_random_phase(6'd5, 27, 67);
        run_random_phase(6'd63, 67, 27);
        run_random_phase(6'd2, 0, 0);

        if (verdicts_due.size() != 0)
            report_fault($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/utf8v_pkg.sv
sv/utf8v_step.sv
sv/utf8_validator_char_limit.sv
test/tb_top.sv
